[sv/depth_pixel_deprojection_core_macros.svh]
// Assertion macros shared by the deprojection RTL.
// Needs signals clk and rst_n in the including module.
`ifndef DEPTH_PIXEL_DEPROJECTION_CORE_MACROS_SVH
`define DEPTH_PIXEL_DEPROJECTION_CORE_MACROS_SVH

// implication checked outside reset
`define DPD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpd check failed");

// next-cycle implication, also active during reset
`define DPD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("dpd check failed");

`endif

[sv/dpd_pkg.sv]
// Types, constants and helpers of the depth pixel deprojection core.
// No dependencies.
package dpd_pkg;

  localparam int QW      = 63;   // signed Q.30 working value, range +-2^61
  localparam int MAG_W   = 62;
  localparam int NUM_W   = 59;   // divider numerator / quotient width
  localparam int F_W     = 32;
  localparam int PIX_W   = 16;
  localparam int PIX_SH  = 42;
  localparam int DIV_LAT = NUM_W + 2;
  localparam int QMUL_LAT = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 64;

  typedef logic signed [QW-1:0] qv_t;

  localparam qv_t Q_LIM  = 63'sh2000_0000_0000_0000;
  localparam qv_t Q_NLIM = -Q_LIM;
  localparam qv_t Q_ONE  = 63'sh4000_0000;
  localparam qv_t P_MAX  = 63'sh7FFF_FFFF;
  localparam qv_t P_MIN  = -(63'sh8000_0000);

  localparam logic [CFG_DAT_W-1:0] FOCAL_RST = 64'd2576980378009600;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODEL, CFG_FOCAL, CFG_PP, CFG_K1, CFG_K2, CFG_K3, CFG_P1, CFG_P2
  } cfg_idx_t;

  typedef struct packed {
    logic               model;
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    logic signed [31:0] k3;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
  } coef_t;

  // saturating add at +-2^61
  function automatic qv_t sadd(qv_t a, qv_t b);
    logic signed [QW:0] s;
    logic signed [QW:0] lim;
    lim = {1'b0, Q_LIM};
    s = {a[QW-1], a} + {b[QW-1], b};
    if (s > lim) sadd = Q_LIM;
    else if (s < -lim) sadd = Q_NLIM;
    else sadd = qv_t'(s[QW-1:0]);
  endfunction

endpackage

[sv/dpd_in_if.sv]
// Pixel input channel of the deprojection core.
// Depends on dpd_pkg.
interface dpd_in_if;
  logic                         valid;
  logic                         ready;
  logic [dpd_pkg::PIX_W-1:0]    pixel_col;
  logic [dpd_pkg::PIX_W-1:0]    pixel_row;
  logic [dpd_pkg::PIX_W-1:0]    depth_value;
  modport source (output valid, pixel_col, pixel_row, depth_value, input ready);
  modport sink (input valid, pixel_col, pixel_row, depth_value, output ready);
endinterface

[sv/dpd_out_if.sv]
// Point output channel of the deprojection core.
// Depends on dpd_pkg.
interface dpd_out_if;
  logic                         valid;
  logic                         ready;
  logic signed [31:0]           point_x;
  logic signed [31:0]           point_y;
  logic [dpd_pkg::PIX_W-1:0]    point_z;
  logic                         overflow_flag;
  modport source (output valid, point_x, point_y, point_z, overflow_flag, input ready);
  modport sink (input valid, point_x, point_y, point_z, overflow_flag, output ready);
endinterface

[sv/dpd_cfg_if.sv]
// Register write channel of the deprojection core.
// Depends on dpd_pkg.
interface dpd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dpd_pkg::CFG_IDX_W-1:0]   index;
  logic [dpd_pkg::CFG_DAT_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/dpd_delay.sv]
// Enable-gated delay line used to align side data with the datapath.
// No dependencies.
module dpd_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] pipe_r [D];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < D; i++) pipe_r[i] <= '0;
    end else if (en) begin
      pipe_r[0] <= d;
      for (int i = 1; i < D; i++) pipe_r[i] <= pipe_r[i-1];
    end
  end

  assign q = pipe_r[D-1];

endmodule

[sv/dpd_div.sv]
// Pipelined normalizer: (pix - pp) / f as signed Q.30, one quotient bit per stage.
// Depends on dpd_pkg.
module dpd_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [dpd_pkg::PIX_W-1:0]     pix,
  input  logic [dpd_pkg::PIX_W-1:0]     pp,
  input  logic [dpd_pkg::F_W-1:0]       f,
  output dpd_pkg::qv_t                  quo
);

  localparam int NW = dpd_pkg::NUM_W;
  localparam int FW = dpd_pkg::F_W;

  logic signed [dpd_pkg::PIX_W:0] diff;
  logic [dpd_pkg::PIX_W:0]        diff_abs;
  logic [FW-1:0]                  fz;
  logic [NW-1:0]                  num_in;

  logic [NW-1:0] num_r [NW+1];
  logic [FW-1:0] rem_r [NW+1];
  logic [NW-1:0] quo_r [NW+1];
  logic          neg_r [NW+1];
  logic [FW-1:0] rem_nxt [1:NW];
  logic          qbit [1:NW];
  dpd_pkg::qv_t  quo_out_r;

  always_comb begin
    diff     = $signed({1'b0, pix}) - $signed({1'b0, pp});
    diff_abs = diff[dpd_pkg::PIX_W] ? (~diff + 1'b1) : diff;
    fz       = (f == '0) ? FW'(1) : f;
    num_in   = NW'({diff_abs[dpd_pkg::PIX_W-1:0], {dpd_pkg::PIX_SH{1'b0}}})
             + NW'(fz[FW-1:1]);
  end

  always_comb begin
    for (int k = 1; k <= NW; k++) begin
      logic [FW:0] t;
      t = {rem_r[k-1], num_r[k-1][NW-1]};
      qbit[k] = (t >= {1'b0, fz});
      rem_nxt[k] = qbit[k] ? FW'(t - {1'b0, fz}) : t[FW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r[0] <= num_in;
      rem_r[0] <= '0;
      quo_r[0] <= '0;
      neg_r[0] <= diff[dpd_pkg::PIX_W];
      for (int k = 1; k <= NW; k++) begin
        num_r[k] <= num_r[k-1] << 1;
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= {quo_r[k-1][NW-2:0], qbit[k]};
        neg_r[k] <= neg_r[k-1];
      end
      quo_out_r <= neg_r[NW] ? -dpd_pkg::qv_t'({4'd0, quo_r[NW]})
                             : dpd_pkg::qv_t'({4'd0, quo_r[NW]});
    end
  end

  assign quo = quo_out_r;

endmodule

[sv/dpd_qmul.sv]
// Four-stage signed fixed-point multiplier: round(a*b / 2^SHIFT), capped at 2^61.
// Depends on dpd_pkg.
module dpd_qmul #(
  parameter int SHIFT = 30
) (
  input  logic         clk,
  input  logic         en,
  input  dpd_pkg::qv_t a,
  input  dpd_pkg::qv_t b,
  output dpd_pkg::qv_t p
);

  localparam int MW = dpd_pkg::MAG_W;
  localparam int HW = MW / 2;
  localparam int PW = 2 * MW;
  localparam logic [PW-1:0] RND = PW'(1) << (SHIFT - 1);
  localparam logic [PW-1:0] CAP = PW'(1) << (MW - 1);

  dpd_pkg::qv_t  abs_a, abs_b;
  logic [MW-1:0] ma_r, mb_r;
  logic          neg1_r, neg2_r, neg3_r;
  logic [MW-1:0] hh_r, hl_r, lh_r, ll_r;
  logic [PW-1:0] prod_r;
  logic [PW-1:0] shv;
  logic [MW-1:0] mres;
  dpd_pkg::qv_t  p_r;

  always_comb begin
    abs_a = a[dpd_pkg::QW-1] ? -a : a;
    abs_b = b[dpd_pkg::QW-1] ? -b : b;
    shv   = prod_r >> SHIFT;
    mres  = (shv > CAP) ? CAP[MW-1:0] : shv[MW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r   <= abs_a[MW-1:0];
      mb_r   <= abs_b[MW-1:0];
      neg1_r <= a[dpd_pkg::QW-1] ^ b[dpd_pkg::QW-1];
      hh_r   <= ma_r[MW-1:HW] * mb_r[MW-1:HW];
      hl_r   <= ma_r[MW-1:HW] * mb_r[HW-1:0];
      lh_r   <= ma_r[HW-1:0]  * mb_r[MW-1:HW];
      ll_r   <= ma_r[HW-1:0]  * mb_r[HW-1:0];
      neg2_r <= neg1_r;
      prod_r <= {hh_r, {MW{1'b0}}} + (PW'(hl_r) << HW) + (PW'(lh_r) << HW)
              + PW'(ll_r) + RND;
      neg3_r <= neg2_r;
      p_r    <= neg3_r ? -dpd_pkg::qv_t'({1'b0, mres}) : dpd_pkg::qv_t'({1'b0, mres});
    end
  end

  assign p = p_r;

endmodule

[sv/dpd_correct.sv]
// Inverse Brown-Conrady correction, depth scaling and output saturation pipeline.
// Depends on dpd_pkg, dpd_qmul, dpd_delay.
module dpd_correct (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       vld,
  input  logic [dpd_pkg::PIX_W-1:0]  depth,
  input  dpd_pkg::qv_t               x,
  input  dpd_pkg::qv_t               y,
  input  dpd_pkg::coef_t             coef,
  output logic                       out_vld,
  output logic signed [31:0]         point_x,
  output logic signed [31:0]         point_y,
  output logic [dpd_pkg::PIX_W-1:0]  point_z,
  output logic                       ovf
);

  localparam int M  = dpd_pkg::QMUL_LAT;
  localparam int QW = dpd_pkg::QW;
  localparam int PW = dpd_pkg::PIX_W;

  dpd_pkg::qv_t k1e, k2e, k3e, p1e, p2e, p1x2, p2x2;
  dpd_pkg::qv_t xx, yy, xy, r4, k1r2, r6, k2r4, k3r6;
  dpd_pkg::qv_t pxy1, pxy2, psx, psy, xf, yf;
  dpd_pkg::qv_t r2_d, k1r2_d, k2r4_d, pxy1_d, pxy2_d, psx_d, psy_d;
  dpd_pkg::qv_t x_d1, y_d1, x_d2, y_d2, vx, vy, dep_q, sxv, syv;
  dpd_pkg::qv_t r2_r, xx2_r, yy2_r, sx_r, sy_r, a1_r, a2_r, f_r;
  dpd_pkg::qv_t ux1_r, uy1_r, ux_r, uy_r;
  logic [PW-1:0] dep_d1, dep_d2;
  logic          vld_d1, vld_d2;
  logic          vld_r, ovf_r;
  logic signed [31:0] px_r, py_r;
  logic [PW-1:0] pz_r;
  logic          ox, oy;
  logic signed [31:0] px_nxt, py_nxt;

  assign k1e  = dpd_pkg::qv_t'(coef.k1);
  assign k2e  = dpd_pkg::qv_t'(coef.k2);
  assign k3e  = dpd_pkg::qv_t'(coef.k3);
  assign p1e  = dpd_pkg::qv_t'(coef.p1);
  assign p2e  = dpd_pkg::qv_t'(coef.p2);
  assign p1x2 = p1e <<< 1;
  assign p2x2 = p2e <<< 1;

  // squares and cross term
  dpd_qmul u_xx (.clk, .en, .a(x), .b(x), .p(xx));
  dpd_qmul u_yy (.clk, .en, .a(y), .b(y), .p(yy));
  dpd_qmul u_xy (.clk, .en, .a(x), .b(y), .p(xy));

  // radial powers and polynomial terms
  dpd_qmul u_r4   (.clk, .en, .a(r2_r), .b(r2_r), .p(r4));
  dpd_qmul u_k1r2 (.clk, .en, .a(k1e),  .b(r2_r), .p(k1r2));
  dpd_delay #(.W(QW), .D(M)) u_r2_dl (.clk, .rst_n, .en, .d(r2_r), .q(r2_d));
  dpd_qmul u_r6   (.clk, .en, .a(r4),   .b(r2_d), .p(r6));
  dpd_qmul u_k2r4 (.clk, .en, .a(k2e),  .b(r4),   .p(k2r4));
  dpd_qmul u_k3r6 (.clk, .en, .a(k3e),  .b(r6),   .p(k3r6));
  dpd_delay #(.W(QW), .D(2*M)) u_k1_dl (.clk, .rst_n, .en, .d(k1r2), .q(k1r2_d));
  dpd_delay #(.W(QW), .D(M))   u_k2_dl (.clk, .rst_n, .en, .d(k2r4), .q(k2r4_d));

  // tangential terms
  dpd_qmul u_pxy1 (.clk, .en, .a(p1x2), .b(xy),   .p(pxy1));
  dpd_qmul u_pxy2 (.clk, .en, .a(p2x2), .b(xy),   .p(pxy2));
  dpd_qmul u_psx  (.clk, .en, .a(p2e),  .b(sx_r), .p(psx));
  dpd_qmul u_psy  (.clk, .en, .a(p1e),  .b(sy_r), .p(psy));
  dpd_delay #(.W(2*QW), .D(3*M+3)) u_pxy_dl (.clk, .rst_n, .en,
    .d({pxy1, pxy2}), .q({pxy1_d, pxy2_d}));
  dpd_delay #(.W(2*QW), .D(3*M+2)) u_ps_dl (.clk, .rst_n, .en,
    .d({psx, psy}), .q({psx_d, psy_d}));

  // undistorted coordinates
  dpd_delay #(.W(2*QW), .D(4*M+3)) u_xy1_dl (.clk, .rst_n, .en,
    .d({x, y}), .q({x_d1, y_d1}));
  dpd_delay #(.W(2*QW), .D(M+2)) u_xy2_dl (.clk, .rst_n, .en,
    .d({x_d1, y_d1}), .q({x_d2, y_d2}));
  dpd_qmul u_xf (.clk, .en, .a(x_d1), .b(f_r), .p(xf));
  dpd_qmul u_yf (.clk, .en, .a(y_d1), .b(f_r), .p(yf));

  always_ff @(posedge clk) begin
    if (en) begin
      r2_r  <= dpd_pkg::sadd(xx, yy);
      xx2_r <= dpd_pkg::sadd(xx, xx);
      yy2_r <= dpd_pkg::sadd(yy, yy);
      sx_r  <= dpd_pkg::sadd(r2_r, xx2_r);
      sy_r  <= dpd_pkg::sadd(r2_r, yy2_r);
      a1_r  <= dpd_pkg::sadd(dpd_pkg::Q_ONE, k1r2_d);
      a2_r  <= dpd_pkg::sadd(k2r4_d, k3r6);
      f_r   <= dpd_pkg::sadd(a1_r, a2_r);
      ux1_r <= dpd_pkg::sadd(xf, pxy1_d);
      uy1_r <= dpd_pkg::sadd(yf, pxy2_d);
      ux_r  <= dpd_pkg::sadd(ux1_r, psx_d);
      uy_r  <= dpd_pkg::sadd(uy1_r, psy_d);
    end
  end

  // depth scaling
  dpd_delay #(.W(PW+1), .D(5*M+5)) u_dep1_dl (.clk, .rst_n, .en,
    .d({vld, depth}), .q({vld_d1, dep_d1}));
  dpd_delay #(.W(PW+1), .D(M)) u_dep2_dl (.clk, .rst_n, .en,
    .d({vld_d1, dep_d1}), .q({vld_d2, dep_d2}));

  assign vx    = coef.model ? ux_r : x_d2;
  assign vy    = coef.model ? uy_r : y_d2;
  assign dep_q = dpd_pkg::qv_t'({{(QW-PW){1'b0}}, dep_d1});

  dpd_qmul #(.SHIFT(18)) u_scx (.clk, .en, .a(vx), .b(dep_q), .p(sxv));
  dpd_qmul #(.SHIFT(18)) u_scy (.clk, .en, .a(vy), .b(dep_q), .p(syv));

  always_comb begin
    ox = (sxv > dpd_pkg::P_MAX) || (sxv < dpd_pkg::P_MIN);
    oy = (syv > dpd_pkg::P_MAX) || (syv < dpd_pkg::P_MIN);
    if (sxv > dpd_pkg::P_MAX) px_nxt = 32'sh7FFF_FFFF;
    else if (sxv < dpd_pkg::P_MIN) px_nxt = 32'sh8000_0000;
    else px_nxt = sxv[31:0];
    if (syv > dpd_pkg::P_MAX) py_nxt = 32'sh7FFF_FFFF;
    else if (syv < dpd_pkg::P_MIN) py_nxt = 32'sh8000_0000;
    else py_nxt = syv[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_d2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r  <= px_nxt;
      py_r  <= py_nxt;
      pz_r  <= dep_d2;
      ovf_r <= ox || oy;
    end
  end

  assign out_vld = vld_r;
  assign point_x = px_r;
  assign point_y = py_r;
  assign point_z = pz_r;
  assign ovf     = ovf_r;

endmodule

[sv/depth_pixel_deprojection_core.sv]
// Depth pixel deprojection core: pinhole model with optional inverse Brown-Conrady.
// Depends on dpd_pkg, dpd_*_if, dpd_div, dpd_delay, dpd_correct, macros header.
//
//   channel   dir   payload                                         transaction
//   in_ch     in    pixel_col, pixel_row, depth_value               valid & ready
//   out_ch    out   point_x, point_y, point_z, overflow_flag        valid & ready
//   cfg_ch    in    index (0..7), data (64b)                        valid & ready
//
// One pixel per cycle while out_ch does not stall; the path runs through the
// 59-stage restoring divider and six chained 4-stage multiplier ranks.
// Synchronous active-low reset clears valid bits and delay lines; lens regs get defaults.
// A stall on out_ch freezes the whole pipeline; in_ch ready follows it.
// cfg_ch is always ready; the user must issue writes only while the pipeline is empty, as the core does not enforce it.
`include "depth_pixel_deprojection_core_macros.svh"

module depth_pixel_deprojection_core (
  input  logic      clk,
  input  logic      rst_n,
  dpd_in_if.sink    in_ch,
  dpd_out_if.source out_ch,
  dpd_cfg_if.sink   cfg_ch
);

  logic                 model_r;
  logic [63:0]          focal_r;
  logic [31:0]          pp_r;
  logic signed [31:0]   k1_r, k2_r, k3_r, p1_r, p2_r;
  dpd_pkg::coef_t       coef;
  logic                 en;
  dpd_pkg::qv_t         xn, yn;
  logic                 vld_d;
  logic [dpd_pkg::PIX_W-1:0] dep_d;
  logic                 out_vld, ovf;
  logic signed [31:0]   px, py;
  logic [dpd_pkg::PIX_W-1:0] pz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      model_r <= 1'b0;
      focal_r <= dpd_pkg::FOCAL_RST;
      pp_r    <= '0;
      k1_r    <= '0;
      k2_r    <= '0;
      k3_r    <= '0;
      p1_r    <= '0;
      p2_r    <= '0;
    end else if (cfg_ch.valid) begin
      case (dpd_pkg::cfg_idx_t'(cfg_ch.index))
        dpd_pkg::CFG_MODEL: model_r <= cfg_ch.data[0];
        dpd_pkg::CFG_FOCAL: focal_r <= cfg_ch.data;
        dpd_pkg::CFG_PP:    pp_r    <= cfg_ch.data[31:0];
        dpd_pkg::CFG_K1:    k1_r    <= cfg_ch.data[31:0];
        dpd_pkg::CFG_K2:    k2_r    <= cfg_ch.data[31:0];
        dpd_pkg::CFG_K3:    k3_r    <= cfg_ch.data[31:0];
        dpd_pkg::CFG_P1:    p1_r    <= cfg_ch.data[31:0];
        dpd_pkg::CFG_P2:    p2_r    <= cfg_ch.data[31:0];
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;
  assign coef = '{model: model_r, k1: k1_r, k2: k2_r, k3: k3_r, p1: p1_r, p2: p2_r};

  assign en          = !out_vld || out_ch.ready;
  assign in_ch.ready = en;

  dpd_div u_div_x (
    .clk, .en, .pix(in_ch.pixel_col), .pp(pp_r[15:0]), .f(focal_r[31:0]), .quo(xn)
  );
  dpd_div u_div_y (
    .clk, .en, .pix(in_ch.pixel_row), .pp(pp_r[31:16]), .f(focal_r[63:32]), .quo(yn)
  );

  dpd_delay #(.W(dpd_pkg::PIX_W+1), .D(dpd_pkg::DIV_LAT)) u_side_dl (
    .clk, .rst_n, .en,
    .d({in_ch.valid, in_ch.depth_value}), .q({vld_d, dep_d})
  );

  dpd_correct u_correct (
    .clk, .rst_n, .en,
    .vld(vld_d), .depth(dep_d), .x(xn), .y(yn), .coef,
    .out_vld, .point_x(px), .point_y(py), .point_z(pz), .ovf
  );

  assign out_ch.valid         = out_vld;
  assign out_ch.point_x       = px;
  assign out_ch.point_y       = py;
  assign out_ch.point_z       = pz;
  assign out_ch.overflow_flag = ovf;

  `DPD_ASSERT_NXT(a_rst_empty, !rst_n, !out_vld)
  `DPD_ASSERT_IMP(a_ovf_bound, out_vld && ovf,
    px == 32'sh7FFF_FFFF || px == 32'sh8000_0000 ||
    py == 32'sh7FFF_FFFF || py == 32'sh8000_0000)
  `DPD_ASSERT_IMP(a_zero_depth, out_vld && pz == '0, px == '0 && py == '0 && !ovf)

endmodule

[verif/tb_top.sv]
// Self-checking testbench for depth_pixel_deprojection_core: random and directed pixels,
// bit-accurate fixed-point prediction of each point, and randomized handshake pressure.
// Depends on dpd_pkg, dpd_in_if, dpd_out_if, dpd_cfg_if and the core RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam longint QLIM  = 64'sd1 << 61;
  localparam longint QUNIT = 64'sd1 << 30;
  localparam int WDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 600;

  typedef struct {
    logic [15:0] col;
    logic [15:0] row;
    logic [15:0] depth;
  } pixel_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] z;
    logic        ovf;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dpd_in_if  in_ch();
  dpd_out_if out_ch();
  dpd_cfg_if cfg_ch();

  depth_pixel_deprojection_core uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always #5 clk = ~clk;

  // shadow copy of the lens registers
  logic        lens_model;
  logic [63:0] lens_focal;
  logic [31:0] lens_pp;
  longint      lens_k1, lens_k2, lens_k3, lens_p1, lens_p2;

  pixel_t pending_pixels[$];
  point_t expected_points[$];
  int     mismatches = 0;
  int     idle_mode = 0;
  int     hold_reqs = 0;
  int     hold_done = 0;
  int     hold_cnt = 0;
  int     quiet_cycles = 0;
  logic   in_fire = 1'b0;

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? 64'd0 - longint'(v) : v;
  endfunction

  function automatic longint unsigned mul_round(longint unsigned a, longint unsigned b,
                                                int sh, longint unsigned cap);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p + (128'd1 << (sh - 1));
    p = p >> sh;
    return (p > {64'd0, cap}) ? cap : p[63:0];
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint unsigned m;
    m = mul_round(magnitude(a), magnitude(b), 30, QLIM);
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint qadd(longint a, longint b);
    longint s;
    s = a + b;
    if (s > QLIM) return QLIM;
    if (s < -QLIM) return -QLIM;
    return s;
  endfunction

  function automatic longint norm_coord(logic [15:0] pix, logic [15:0] pp, logic [31:0] f);
    longint d;
    longint unsigned m, fd, q;
    d  = longint'({48'd0, pix}) - longint'({48'd0, pp});
    m  = magnitude(d) << 42;
    fd = (f == 0) ? 64'd1 : {32'd0, f};
    q  = (m + (fd >> 1)) / fd;
    return d < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [31:0] scale_depth(longint v, logic [15:0] depth, inout logic ovf);
    longint unsigned m;
    m = mul_round(magnitude(v), {48'd0, depth}, 18, QLIM);
    if (v < 0) begin
      if (m > 64'h8000_0000) begin
        ovf = 1'b1;
        m = 64'h8000_0000;
      end
      return 32'd0 - m[31:0];
    end
    if (m > 64'h7FFF_FFFF) begin
      ovf = 1'b1;
      m = 64'h7FFF_FFFF;
    end
    return m[31:0];
  endfunction

  function automatic point_t deproject_point(pixel_t px);
    point_t r;
    longint x, y, xx, yy, xy, r2, r4, r6, gain, ux, uy;
    logic ovf;
    ovf = 1'b0;
    x = norm_coord(px.col, lens_pp[15:0], lens_focal[31:0]);
    y = norm_coord(px.row, lens_pp[31:16], lens_focal[63:32]);
    if (lens_model) begin
      xx = qmul(x, x);
      yy = qmul(y, y);
      xy = qmul(x, y);
      r2 = qadd(xx, yy);
      r4 = qmul(r2, r2);
      r6 = qmul(r4, r2);
      gain = qadd(qadd(QUNIT, qmul(lens_k1, r2)),
                  qadd(qmul(lens_k2, r4), qmul(lens_k3, r6)));
      ux = qadd(qadd(qmul(x, gain), qmul(2 * lens_p1, xy)),
                qmul(lens_p2, qadd(r2, qadd(xx, xx))));
      uy = qadd(qadd(qmul(y, gain), qmul(2 * lens_p2, xy)),
                qmul(lens_p1, qadd(r2, qadd(yy, yy))));
      x = ux;
      y = uy;
    end
    r.x = scale_depth(x, px.depth, ovf);
    r.y = scale_depth(y, px.depth, ovf);
    r.z = px.depth;
    r.ovf = ovf;
    return r;
  endfunction

  function automatic bit idle_roll(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // pixel driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (pending_pixels.size() > 0 &&
          !((idle_mode == 1 && idle_roll(48)) || (idle_mode == 3 && idle_roll(32)))) begin
        pixel_t p;
        p = pending_pixels.pop_front();
        in_ch.pixel_col   <= p.col;
        in_ch.pixel_row   <= p.row;
        in_ch.depth_value <= p.depth;
        in_ch.valid       <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // accepted pixels -> expected points
  always @(posedge clk) begin
    in_fire <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      pixel_t p;
      p.col = in_ch.pixel_col;
      p.row = in_ch.pixel_row;
      p.depth = in_ch.depth_value;
      expected_points.push_back(deproject_point(p));
    end
  end

  // result ready, with random stalls and the long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_reqs != hold_done) begin
      hold_done <= hold_reqs;
      hold_cnt <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !((idle_mode == 2 && idle_roll(48)) ||
                        (idle_mode == 3 && idle_roll(32)));
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected point x=%h y=%h z=%h ovf=%b", out_ch.point_x,
                   out_ch.point_y, out_ch.point_z, out_ch.overflow_flag);
      end else begin
        point_t e;
        e = expected_points.pop_front();
        if (e.x !== out_ch.point_x || e.y !== out_ch.point_y ||
            e.z !== out_ch.point_z || e.ovf !== out_ch.overflow_flag) begin
          mismatches++;
          if (mismatches <= 10)
            $display("point mismatch: exp x=%h y=%h z=%h ovf=%b got x=%h y=%h z=%h ovf=%b",
                     e.x, e.y, e.z, e.ovf, out_ch.point_x, out_ch.point_y,
                     out_ch.point_z, out_ch.overflow_flag);
        end
      end
    end
  end

  // watchdog on transactions
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(dpd_pkg::cfg_idx_t idx, logic [63:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      dpd_pkg::CFG_MODEL: lens_model = value[0];
      dpd_pkg::CFG_FOCAL: lens_focal = value;
      dpd_pkg::CFG_PP:    lens_pp = value[31:0];
      dpd_pkg::CFG_K1:    lens_k1 = longint'(signed'(value[31:0]));
      dpd_pkg::CFG_K2:    lens_k2 = longint'(signed'(value[31:0]));
      dpd_pkg::CFG_K3:    lens_k3 = longint'(signed'(value[31:0]));
      dpd_pkg::CFG_P1:    lens_p1 = longint'(signed'(value[31:0]));
      dpd_pkg::CFG_P2:    lens_p2 = longint'(signed'(value[31:0]));
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic load_lens(logic model, logic [63:0] focal, logic [31:0] pp,
                           logic [31:0] k1, logic [31:0] k2, logic [31:0] k3,
                           logic [31:0] p1, logic [31:0] p2);
    write_reg(dpd_pkg::CFG_MODEL, {63'd0, model});
    write_reg(dpd_pkg::CFG_FOCAL, focal);
    write_reg(dpd_pkg::CFG_PP, {32'd0, pp});
    write_reg(dpd_pkg::CFG_K1, {32'd0, k1});
    write_reg(dpd_pkg::CFG_K2, {32'd0, k2});
    write_reg(dpd_pkg::CFG_K3, {32'd0, k3});
    write_reg(dpd_pkg::CFG_P1, {32'd0, p1});
    write_reg(dpd_pkg::CFG_P2, {32'd0, p2});
  endtask

  task automatic add_pixel(logic [15:0] col, logic [15:0] row, logic [15:0] depth);
    pixel_t p;
    p.col = col;
    p.row = row;
    p.depth = depth;
    pending_pixels.push_back(p);
  endtask

  task automatic add_random_pixels(int n);
    int kind, c, r;
    logic [15:0] d;
    repeat (n) begin
      kind = $urandom_range(0, 9);
      d = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 8000));
      if (kind == 0) begin
        add_pixel(16'($urandom), 16'($urandom), 16'($urandom));
      end else if (kind == 1) begin
        add_pixel(16'($urandom), 16'($urandom), $urandom_range(0, 1) ? 16'd0 : 16'hFFFF);
      end else if (kind == 2) begin
        add_pixel($urandom_range(0, 1) ? 16'hFFFF : 16'd0,
                  $urandom_range(0, 1) ? 16'hFFFF : 16'd0, d);
      end else begin
        c = int'(lens_pp[15:0]) + $urandom_range(0, 20480) - 10240;
        r = int'(lens_pp[31:16]) + $urandom_range(0, 15360) - 7680;
        c = c < 0 ? 0 : (c > 65535 ? 65535 : c);
        r = r < 0 ? 0 : (r > 65535 ? 65535 : r);
        add_pixel(c[15:0], r[15:0], d);
      end
    end
  endtask

  task automatic drain();
    while (pending_pixels.size() > 0 || expected_points.size() > 0 || in_ch.valid)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [31:0] small_coef();
    return 32'($urandom_range(0, 1 << 28)) - 32'(1 << 27);
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.pixel_col = '0;
    in_ch.pixel_row = '0;
    in_ch.depth_value = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = dpd_pkg::CFG_MODEL;
    cfg_ch.data = '0;
    lens_model = 1'b0;
    lens_focal = dpd_pkg::FOCAL_RST;
    lens_pp = '0;
    {lens_k1, lens_k2, lens_k3, lens_p1, lens_p2} = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset lens: corners, zero depth, full depth
    add_pixel(16'd0, 16'd0, 16'd0);
    add_pixel(16'd0, 16'd0, 16'd1000);
    add_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_pixel(16'hFFFF, 16'd0, 16'd1);
    add_pixel(16'd0, 16'hFFFF, 16'hFFFF);
    drain();

    // centered pinhole, pixel on the principal point
    load_lens(1'b0, {32'd600 << 16, 32'd610 << 16}, {16'd240 << 4, 16'd320 << 4},
              '0, '0, '0, '0, '0);
    add_pixel(16'd320 << 4, 16'd240 << 4, 16'hFFFF);
    add_pixel(16'd0, 16'd0, 16'hFFFF);
    add_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    drain();

    // zero focal lengths saturate off-center pixels that have a nonzero depth
    load_lens(1'b0, 64'd0, 32'hFFFF_FFFF, '0, '0, '0, '0, '0);
    add_pixel(16'd0, 16'd0, 16'd1);
    add_pixel(16'hFFFF, 16'hFFFF, 16'd5);
    add_pixel(16'd0, 16'hFFFF, 16'd0);
    add_pixel(16'h1234, 16'hFFFF, 16'd3);
    drain();

    // distortion with extreme coefficients: intermediate saturation
    load_lens(1'b1, {32'd1 << 10, 32'd1 << 10}, 32'h0000_0000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    add_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_pixel(16'hFFFF, 16'd0, 16'd1);
    add_pixel(16'd0, 16'd0, 16'd500);
    add_pixel(16'd7, 16'd3, 16'd0);
    add_pixel(16'd40, 16'd2, 16'd100);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: load_lens(1'b1, {32'd600 << 16, 32'd605 << 16}, {16'd240 << 4, 16'd320 << 4},
                     small_coef(), small_coef(), small_coef(), small_coef() >>> 4,
                     small_coef() >>> 4);
        1: load_lens(1'b0, {32'($urandom), 32'($urandom)}, $urandom,
                     $urandom, $urandom, $urandom, $urandom, $urandom);
        2: load_lens(1'b1, {32'($urandom_range(100, 2000)) << 16,
                            32'($urandom_range(100, 2000)) << 16},
                     {16'($urandom_range(0, 1000)) << 4, 16'($urandom_range(0, 1000)) << 4},
                     small_coef(), small_coef(), small_coef(), small_coef(), small_coef());
        default: load_lens(1'b1, {32'($urandom), 32'($urandom)}, $urandom,
                           $urandom, $urandom, $urandom, $urandom, $urandom);
      endcase
      idle_mode = ph % 4;
      if (ph == 1 || ph == 6) hold_reqs++;
      add_random_pixels(215);
      drain();
    end

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/dpd_pkg.sv
sv/dpd_in_if.sv
sv/dpd_out_if.sv
sv/dpd_cfg_if.sv
sv/dpd_delay.sv
sv/dpd_div.sv
sv/dpd_qmul.sv
sv/dpd_correct.sv
sv/depth_pixel_deprojection_core.sv
verif/tb_top.sv
